// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros shared by the RTL; reset disables every check.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ----- src/pfr_pkg.sv -----
// ----------------------------------------------------------------------------
// pfr_pkg
// Shared constants and inter-module types of the page frame replacement block.
// ----------------------------------------------------------------------------
package pfr_pkg;

    // Defaults and capacity limits
    localparam int FRAME_CNT_DEF  = 4;
    localparam int PAGE_BITS_DEF  = 16;
    localparam int IDX_MAX_W      = 4;   // frame index, up to 16 frames
    localparam int RANK_MAX_W     = 4;   // recency rank, up to 16 frames
    localparam int ACT_W          = 5;   // active frame count 1..16
    localparam int PAGE_MAX_W     = 32;  // stored page, up to 32 bits

    // Port widths
    localparam int PAGE_IN_W  = 16;
    localparam int FIDX_OUT_W = 2;
    localparam int CNT_W      = 32;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 3;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 88;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_POLICY_MODE   = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAMES_IN_USE = 1'd1;

    // Policy codes
    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    // Reset values of the configuration registers
    localparam logic                  POLICY_RST = POLICY_LRU;
    localparam logic [CFG_DATA_W-1:0] FRAMES_RST = 3'd4;

    // Running summary handed from cell to cell during a sweep
    typedef struct packed {
        logic                  hit_found;
        logic [IDX_MAX_W-1:0]  hit_idx;
        logic [RANK_MAX_W-1:0] hit_rank;
        logic                  empty_found;
        logic [IDX_MAX_W-1:0]  empty_idx;
        logic [RANK_MAX_W-1:0] fifo_rank;
        logic [PAGE_MAX_W-1:0] fifo_page;
        logic [RANK_MAX_W-1:0] best_rank;
        logic [IDX_MAX_W-1:0]  best_idx;
        logic [PAGE_MAX_W-1:0] best_page;
    } sweep_sum_t;

    // Per-reference context held steady across the sweep
    typedef struct packed {
        logic [PAGE_MAX_W-1:0] page;
        logic [ACT_W-1:0]      active_n;
        logic [IDX_MAX_W-1:0]  fifo_idx;
    } ref_ctx_t;

    // Update broadcast to every cell at the end of a reference
    typedef struct packed {
        logic                  en;
        logic [IDX_MAX_W-1:0]  target;
        logic                  write;
        logic                  age_all;
        logic [RANK_MAX_W-1:0] limit;
    } frame_upd_t;

endpackage

// ----- src/pfr_cell.sv -----
// ----------------------------------------------------------------------------
// pfr_cell
// One page frame: page, valid bit and recency rank, plus one stage of the
// lookup sweep that passes a running summary on to the next frame.
// ----------------------------------------------------------------------------
module pfr_cell
    import pfr_pkg::*;
#(
    parameter int FRAME_CNT = FRAME_CNT_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF,
    parameter int IDX       = 0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       tok_in,
    input  sweep_sum_t sum_in,
    input  ref_ctx_t   ctx,
    input  frame_upd_t upd,
    output logic       tok_out,
    output sweep_sum_t sum_out
);

    localparam int RANK_W = (FRAME_CNT > 1) ? $clog2(FRAME_CNT) : 1;
    localparam logic [RANK_W-1:0]    RANK_MAX = RANK_W'(FRAME_CNT - 1);
    localparam logic [IDX_MAX_W-1:0] MY_IDX   = IDX_MAX_W'(IDX);

    logic                  valid_reg;
    logic [RANK_W-1:0]     rank_reg;
    logic [PAGE_BITS-1:0]  page_reg;
    logic                  tok_reg;
    sweep_sum_t            sum_reg;
    sweep_sum_t            sum_next;

    logic                  active;
    logic [RANK_MAX_W-1:0] rank_ext;
    logic [PAGE_MAX_W-1:0] page_ext;
    logic                  is_target;
    logic                  ages;

    assign active    = ACT_W'(IDX) < ctx.active_n;
    assign rank_ext  = RANK_MAX_W'(rank_reg);
    assign page_ext  = PAGE_MAX_W'(page_reg);
    assign is_target = upd.target == MY_IDX;
    assign ages      = active && valid_reg && (upd.age_all || rank_ext < upd.limit)
                       && rank_reg < RANK_MAX;

    // Fold this frame into the running summary
    always_comb
    begin
        sum_next = sum_in;
        if (active)
        begin
            if (valid_reg && page_ext == ctx.page && !sum_in.hit_found)
            begin
                sum_next.hit_found = 1'b1;
                sum_next.hit_idx   = MY_IDX;
                sum_next.hit_rank  = rank_ext;
            end
            if (!valid_reg && !sum_in.empty_found)
            begin
                sum_next.empty_found = 1'b1;
                sum_next.empty_idx   = MY_IDX;
            end
            if (ctx.fifo_idx == MY_IDX)
            begin
                sum_next.fifo_rank = rank_ext;
                sum_next.fifo_page = page_ext;
            end
            // oldest frame, lowest index wins a tie
            if (IDX == 0 || rank_ext > sum_in.best_rank)
            begin
                sum_next.best_rank = rank_ext;
                sum_next.best_idx  = MY_IDX;
                sum_next.best_page = page_ext;
            end
        end
    end

    // Sweep stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_in)
        begin
            sum_reg <= sum_next;
        end
    end

    // Frame state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else if (upd.en)
        begin
            if (is_target)
            begin
                rank_reg <= '0;
                if (upd.write)
                begin
                    valid_reg <= 1'b1;
                end
            end
            else if (ages)
            begin
                rank_reg <= rank_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd.en && is_target && upd.write)
        begin
            page_reg <= ctx.page[PAGE_BITS-1:0];
        end
    end

    assign tok_out = tok_reg;
    assign sum_out = sum_reg;

endmodule

// ----- src/page_frame_replacement.sv -----
// ----------------------------------------------------------------------------
// page_frame_replacement
// FIFO / LRU page replacement over a small set of page frames.
// ----------------------------------------------------------------------------
// One reference is handled at a time: the reference is taken while idle, a
// launch state starts the sweep, the lookup summary then steps through the row
// of frame cells, and a finish state commits the update and registers the
// result. s_tready is high only while idle. The result waits in an output
// register; a stalled result holds the commit. Frames whose valid bit is clear
// are never read, so stored pages need no reset. policy_mode and frames_in_use
// may only be written while idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module page_frame_replacement
    import pfr_pkg::*;
#(
    parameter int FRAME_CNT = FRAME_CNT_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration
    input  logic                   cfg_we,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    // references
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [15:0] page_number
    // results
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // [0] hit, [2:1] frame used,
                                              // [3] evicted_valid,
                                              // [19:4] evicted_page,
                                              // [51:20] hit_total,
                                              // [83:52] miss_total, zero pad
);

    localparam int PTR_W = (FRAME_CNT > 1) ? $clog2(FRAME_CNT) : 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LAUNCH = 2'd1;
    localparam logic [1:0] ST_SWEEP  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic                   policy_reg;
    logic [CFG_DATA_W-1:0]  frames_reg;
    logic [PTR_W-1:0]       fifo_ptr_reg;
    logic [CNT_W-1:0]       hit_cnt_reg, miss_cnt_reg;
    ref_ctx_t               ctx_reg;
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic                   accept;
    logic                   finish;
    logic [ACT_W-1:0]       active_n;
    logic [ACT_W-1:0]       fifo_sel;
    logic [PAGE_MAX_W-1:0]  page_in;

    logic                   tok   [0:FRAME_CNT];
    sweep_sum_t             sums  [0:FRAME_CNT];
    sweep_sum_t             res;
    frame_upd_t             upd;

    logic                   is_evict;
    logic                   fifo_evict;
    logic [PAGE_MAX_W-1:0]  ev_page;
    logic [ACT_W-1:0]       ptr_inc;
    logic [PTR_W-1:0]       fifo_ptr_next;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POLICY_RST;
            frames_reg <= FRAMES_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_POLICY_MODE:   policy_reg <= cfg_wdata[0];
                REG_FRAMES_IN_USE: frames_reg <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // Active frame count, clamped to 1..FRAME_CNT
    always_comb
    begin
        if (frames_reg == '0)
        begin
            active_n = ACT_W'(1);
        end
        else if (ACT_W'(frames_reg) > ACT_W'(FRAME_CNT))
        begin
            active_n = ACT_W'(FRAME_CNT);
        end
        else
        begin
            active_n = ACT_W'(frames_reg);
        end
    end

    // Page taken modulo 2^PAGE_BITS; a stale FIFO pointer acts as frame 0
    always_comb
    begin
        page_in = '0;
        for (int b = 0; b < PAGE_BITS; b++)
        begin
            if (b < PAGE_IN_W)
            begin
                page_in[b] = s_tdata[b];
            end
        end
    end

    assign fifo_sel = (ACT_W'(fifo_ptr_reg) < active_n) ? ACT_W'(fifo_ptr_reg) : '0;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = state_reg == ST_IDLE;
    assign finish   = state_reg == ST_FINISH && (!out_valid_reg || m_tready);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ctx_reg.page     <= page_in;
            ctx_reg.active_n <= active_n;
            ctx_reg.fifo_idx <= IDX_MAX_W'(fifo_sel);
        end
    end

    // Row of frame cells
    assign tok[0]  = state_reg == ST_LAUNCH;
    assign sums[0] = '0;

    for (genvar g = 0; g < FRAME_CNT; g++)
    begin : g_cell
        pfr_cell #(
            .FRAME_CNT (FRAME_CNT),
            .PAGE_BITS (PAGE_BITS),
            .IDX       (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok[g]),
            .sum_in  (sums[g]),
            .ctx     (ctx_reg),
            .upd     (upd),
            .tok_out (tok[g+1]),
            .sum_out (sums[g+1])
        );
    end

    assign res = sums[FRAME_CNT];

    // Decision: hit, fill of an empty frame, or replacement
    assign is_evict   = !res.hit_found && !res.empty_found;
    assign fifo_evict = is_evict && policy_reg == POLICY_FIFO;

    always_comb
    begin
        upd         = '0;
        upd.en      = finish;
        ev_page     = '0;
        if (res.hit_found)
        begin
            upd.target = res.hit_idx;
            upd.limit  = res.hit_rank;
        end
        else if (res.empty_found)
        begin
            upd.target  = res.empty_idx;
            upd.write   = 1'b1;
            upd.age_all = 1'b1;
        end
        else if (policy_reg == POLICY_FIFO)
        begin
            upd.target = ctx_reg.fifo_idx;
            upd.write  = 1'b1;
            upd.limit  = res.fifo_rank;
            ev_page    = res.fifo_page;
        end
        else
        begin
            upd.target = res.best_idx;
            upd.write  = 1'b1;
            upd.limit  = res.best_rank;
            ev_page    = res.best_page;
        end
    end

    assign ptr_inc       = ACT_W'(ctx_reg.fifo_idx) + 1'b1;
    assign fifo_ptr_next = (ptr_inc < ctx_reg.active_n) ? PTR_W'(ptr_inc) : '0;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (accept)         state_next = ST_LAUNCH;
            ST_LAUNCH:                     state_next = ST_SWEEP;
            ST_SWEEP:  if (tok[FRAME_CNT]) state_next = ST_FINISH;
            ST_FINISH: if (finish)         state_next = ST_IDLE;
            default:                       state_next = ST_IDLE;
        endcase
    end

    // Control, counters and FIFO pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fifo_ptr_reg  <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
            begin
                out_valid_reg <= 1'b1;
                if (fifo_evict)
                begin
                    fifo_ptr_reg <= fifo_ptr_next;
                end
                if (res.hit_found)
                begin
                    if (hit_cnt_reg != '1)
                    begin
                        hit_cnt_reg <= hit_cnt_reg + 1'b1;
                    end
                end
                else if (miss_cnt_reg != '1)
                begin
                    miss_cnt_reg <= miss_cnt_reg + 1'b1;
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_data_reg <= {
                4'd0,
                (res.hit_found || miss_cnt_reg == '1) ? miss_cnt_reg
                                                      : miss_cnt_reg + 1'b1,
                (!res.hit_found || hit_cnt_reg == '1) ? hit_cnt_reg
                                                      : hit_cnt_reg + 1'b1,
                ev_page[PAGE_IN_W-1:0],
                is_evict,
                FIDX_OUT_W'(upd.target),
                res.hit_found
            };
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Checks
    `ASSERT_NEXT(a_accept_launches, clk, rst_n, accept, state_reg == ST_LAUNCH)
    `ASSERT_IMPL(a_sweep_end_in_sweep, clk, rst_n, tok[FRAME_CNT], state_reg == ST_SWEEP)
    `ASSERT_IMPL(a_counts_move_on_finish, clk, rst_n,
        hit_cnt_reg != $past(hit_cnt_reg) || miss_cnt_reg != $past(miss_cnt_reg),
        $past(finish))

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for page_frame_replacement. Page references go in on
// the slave stream; each result is checked against its typed directed row or
// a behavioural predictor of the frame set (FIFO and LRU replacement, recency
// ranks, saturating counters). A short directed table comes first, then
// random reference streams over a sequence of policy and frame-count settings,
// with random idling on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
    import pfr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAMES          = FRAME_CNT_DEF;
    localparam int RANDOM_PHASES   = 11;
    localparam int REFS_PER_PHASE  = 50;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 30;
    localparam int CYCLE_LIMIT     = 200000;

    // One result transfer, field by field
    typedef struct packed {
        logic        hit;
        logic [1:0]  frame;
        logic        ev_valid;
        logic [15:0] ev_page;
        logic [31:0] hits;
        logic [31:0] misses;
    } outcome_t;

    typedef enum logic [1:0] {ROW_WRITE, ROW_REF, ROW_REF_TYPED} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_ADDR_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0] value;
        logic [15:0]           page;
        outcome_t              want;
    } plan_row_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;   // [15:0] page_number
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;          // [0] hit, [2:1] frame used,
                                              // [3] evicted_valid,
                                              // [19:4] evicted_page,
                                              // [51:20] hit_total,
                                              // [83:52] miss_total, zero pad

    page_frame_replacement dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Predictor state: frame contents, ranks, pointer, counters, registers
    logic [15:0]           pages_held [FRAMES];
    logic                  held_valid [FRAMES];
    logic [1:0]            age_rank   [FRAMES];
    int unsigned           fifo_next;
    logic [31:0]           hit_count;
    logic [31:0]           miss_count;
    logic                  policy_now;
    logic [CFG_DATA_W-1:0] frames_cfg;

    outcome_t    pending_outcomes [$];
    plan_row_t   plan [$];
    logic [15:0] hot_pages [FRAMES + 2];
    int          errors         = 0;
    int          refs_checked   = 0;
    int          hits_seen      = 0;
    int          evictions_seen = 0;
    int          settings_used  = 1;
    int          idle_pct       = 11;
    int          stall_pct      = 11;
    logic        pressure_go    = 1'b0;
    logic        pressure_done  = 1'b0;
    int          hold_count     = 0;
    int          cycle_count    = 0;

    // Clock
    initial begin
        forever #5 clk = ~clk;
    end

    // Run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    function automatic int unsigned active_frames();
        if (frames_cfg == 0)
            return 1;
        if (frames_cfg > FRAMES)
            return FRAMES;
        return frames_cfg;
    endfunction

    // Make frame f most recent; frames younger than limit age by one
    function automatic void promote(int unsigned f, int unsigned n, int unsigned limit);
        for (int i = 0; i < n; i++)
            if (i != f && held_valid[i] && age_rank[i] < limit && age_rank[i] < FRAMES - 1)
                age_rank[i]++;
        age_rank[f] = '0;
    endfunction

    // Expected result of one reference; advances the predictor state
    function automatic outcome_t predict_reference(input logic [15:0] page);
        outcome_t    res;
        int unsigned n;
        int unsigned f;
        int unsigned best;
        bit          found;
        res   = '0;
        n     = active_frames();
        f     = 0;
        found = 1'b0;
        for (int i = 0; i < n; i++)
            if (!found && held_valid[i] && pages_held[i] == page) begin
                f     = i;
                found = 1'b1;
            end
        if (found) begin
            res.hit = 1'b1;
            promote(f, n, age_rank[f]);
            if (hit_count != '1)
                hit_count++;
        end else begin
            for (int i = 0; i < n; i++)
                if (!found && !held_valid[i]) begin
                    f     = i;
                    found = 1'b1;
                end
            if (found) begin
                // fill the lowest empty active frame
                held_valid[f] = 1'b1;
                pages_held[f] = page;
                promote(f, n, FRAMES);
            end else begin
                if (policy_now == POLICY_FIFO) begin
                    f         = (fifo_next < n) ? fifo_next : 0;
                    fifo_next = (f + 1 < n) ? f + 1 : 0;
                end else begin
                    // oldest rank wins, lowest index on a tie
                    best = 0;
                    f    = 0;
                    for (int i = 0; i < n; i++)
                        if (age_rank[i] > best) begin
                            best = age_rank[i];
                            f    = i;
                        end
                end
                res.ev_valid  = 1'b1;
                res.ev_page   = pages_held[f];
                pages_held[f] = page;
                promote(f, n, age_rank[f]);
            end
            if (miss_count != '1)
                miss_count++;
        end
        res.frame  = f[1:0];
        res.hits   = hit_count;
        res.misses = miss_count;
        return res;
    endfunction

    function automatic plan_row_t write_row(logic [CFG_ADDR_W-1:0] idx,
                                            logic [CFG_DATA_W-1:0] val);
        plan_row_t r;
        r         = '{kind: ROW_WRITE, default: '0};
        r.reg_idx = idx;
        r.value   = val;
        return r;
    endfunction

    function automatic plan_row_t ref_row(logic [15:0] page);
        plan_row_t r;
        r      = '{kind: ROW_REF, default: '0};
        r.page = page;
        return r;
    endfunction

    function automatic plan_row_t typed_row(logic [15:0] page, outcome_t want);
        plan_row_t r;
        r      = '{kind: ROW_REF_TYPED, default: '0};
        r.page = page;
        r.want = want;
        return r;
    endfunction

    // Offer one reference, idling at random first; returns on the transfer
    task automatic send_reference(input logic [15:0] page);
        cfg_we <= 1'b0;
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= page;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic issue_reference(input logic [15:0] page);
        send_reference(page);
        pending_outcomes.push_back(predict_reference(page));
    endtask

    // Stop offering and wait until every expected result has been taken
    task automatic wait_idle();
        cfg_we   <= 1'b0;
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // Register write; cfg_we is lowered by whatever comes next
    task automatic write_register(input logic [CFG_ADDR_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        if (idx == REG_POLICY_MODE)
            policy_now = val[0];
        else
            frames_cfg = val;
    endtask

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    // Receiver: random stalls, one long hold-off, result checking
    always @(posedge clk) begin
        outcome_t got;
        outcome_t want;
        if (m_tvalid && m_tready) begin
            got.hit      = m_tdata[0];
            got.frame    = m_tdata[2:1];
            got.ev_valid = m_tdata[3];
            got.ev_page  = m_tdata[19:4];
            got.hits     = m_tdata[51:20];
            got.misses   = m_tdata[83:52];
            if (pending_outcomes.size() == 0) begin
                errors++;
                $display("%0t: unexpected result transfer, got 0x%0h", $time, m_tdata);
            end else begin
                want = pending_outcomes.pop_front();
                report_field("hit", want.hit, got.hit);
                report_field("frame used", want.frame, got.frame);
                report_field("evicted_valid", want.ev_valid, got.ev_valid);
                report_field("evicted_page", want.ev_page, got.ev_page);
                report_field("hit_total", want.hits, got.hits);
                report_field("miss_total", want.misses, got.misses);
                refs_checked++;
                hits_seen      += want.hit;
                evictions_seen += want.ev_valid;
            end
        end
        if (pressure_go && !pressure_done) begin
            m_tready <= 1'b0;
            hold_count++;
            if (hold_count >= HOLD_CYCLES)
                pressure_done <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Stimulus
    initial begin
        logic [CFG_DATA_W-1:0] pick_frames;
        logic                  pick_policy;
        int unsigned           pool_size;
        int unsigned           roll;
        logic [15:0]           page;

        // predictor reset state
        for (int i = 0; i < FRAMES; i++) begin
            pages_held[i] = '0;
            held_valid[i] = 1'b0;
            age_rank[i]   = '0;
        end
        fifo_next  = 0;
        hit_count  = '0;
        miss_count = '0;
        policy_now = POLICY_RST;
        frames_cfg = FRAMES_RST;

        // Directed: fill from reset in LRU, then FIFO, frame-count clamping,
        // inactive frames, stale FIFO pointer and a duplicate left behind
        plan.push_back(typed_row(16'h0000, '{1'b0, 2'd0, 1'b0, 16'h0000, 32'd0, 32'd1}));
        plan.push_back(typed_row(16'hFFFF, '{1'b0, 2'd1, 1'b0, 16'h0000, 32'd0, 32'd2}));
        plan.push_back(typed_row(16'h0000, '{1'b1, 2'd0, 1'b0, 16'h0000, 32'd1, 32'd2}));
        plan.push_back(typed_row(16'h1234, '{1'b0, 2'd2, 1'b0, 16'h0000, 32'd1, 32'd3}));
        plan.push_back(typed_row(16'h8000, '{1'b0, 2'd3, 1'b0, 16'h0000, 32'd1, 32'd4}));
        plan.push_back(typed_row(16'h0001, '{1'b0, 2'd1, 1'b1, 16'hFFFF, 32'd1, 32'd5}));
        plan.push_back(ref_row(16'h1234));
        plan.push_back(ref_row(16'h7FFF));
        plan.push_back(write_row(REG_POLICY_MODE, {2'b00, POLICY_FIFO}));
        plan.push_back(ref_row(16'h5555));
        plan.push_back(ref_row(16'hAAAA));
        plan.push_back(ref_row(16'h5555));
        plan.push_back(write_row(REG_FRAMES_IN_USE, 3'd0));
        plan.push_back(ref_row(16'h00FF));
        plan.push_back(ref_row(16'hAAAA));
        plan.push_back(write_row(REG_POLICY_MODE, {2'b01, POLICY_LRU}));
        plan.push_back(ref_row(16'hAAAA));
        plan.push_back(write_row(REG_FRAMES_IN_USE, 3'd7));
        plan.push_back(ref_row(16'hAAAA));
        plan.push_back(ref_row(16'h0F0F));
        plan.push_back(write_row(REG_FRAMES_IN_USE, 3'd2));
        plan.push_back(ref_row(16'h0F0F));
        plan.push_back(ref_row(16'hFFFF));
        plan.push_back(write_row(REG_POLICY_MODE, {2'b10, POLICY_FIFO}));
        plan.push_back(write_row(REG_FRAMES_IN_USE, 3'd3));
        plan.push_back(ref_row(16'h8001));
        plan.push_back(ref_row(16'h4002));
        plan.push_back(ref_row(16'h2004));
        plan.push_back(write_row(REG_FRAMES_IN_USE, 3'd5));
        plan.push_back(write_row(REG_POLICY_MODE, {2'b11, POLICY_LRU}));
        plan.push_back(ref_row(16'h0000));
        plan.push_back(ref_row(16'hFFFF));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[r]) begin
            case (plan[r].kind)
                ROW_WRITE: begin
                    if (cfg_we == 1'b0)
                        settings_used++;
                    wait_idle();
                    write_register(plan[r].reg_idx, plan[r].value);
                end
                ROW_REF_TYPED: begin
                    send_reference(plan[r].page);
                    void'(predict_reference(plan[r].page));
                    pending_outcomes.push_back(plan[r].want);
                end
                default: issue_reference(plan[r].page);
            endcase
        end

        for (int i = 0; i < FRAMES + 2; i++)
            hot_pages[i] = 16'($urandom);

        // Random phases; the first few pin the extremes of both registers
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_idle();
            case (p)
                0:       begin pick_policy = POLICY_FIFO; pick_frames = 3'd1; end
                1:       begin pick_policy = POLICY_LRU;  pick_frames = 3'd4; end
                2:       begin pick_policy = POLICY_FIFO; pick_frames = 3'd4; end
                3:       begin pick_policy = POLICY_LRU;  pick_frames = 3'd7; end
                4:       begin pick_policy = POLICY_FIFO; pick_frames = 3'd0; end
                default: begin
                    pick_policy = 1'($urandom_range(1));
                    pick_frames = 3'($urandom_range(7));
                end
            endcase
            if (p < 5 || $urandom_range(2) != 0)
                write_register(REG_POLICY_MODE, {2'($urandom), pick_policy});
            if (p < 5 || $urandom_range(2) != 0)
                write_register(REG_FRAMES_IN_USE, pick_frames);
            settings_used++;

            // long hold-off at the receiver while references keep coming
            if (p == 2)
                pressure_go <= 1'b1;
            // one phase with no idling on either side
            idle_pct  = (p == 3) ? 0 : 11;
            stall_pct <= (p == 3) ? 0 : 11;

            // keep most of the hot set so old pages can hit in regrown frames
            for (int k = 0; k < 2; k++)
                hot_pages[$urandom_range(FRAMES + 1)] = 16'($urandom);
            pool_size = active_frames() + 2;

            for (int k = 0; k < REFS_PER_PHASE; k++) begin
                roll = $urandom_range(99);
                page = hot_pages[$urandom_range(pool_size - 1)];
                if (roll >= 90)
                    page = 16'($urandom);
                else if (roll >= 75)
                    page = page ^ (16'h0001 << $urandom_range(15));
                issue_reference(page);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d references (%0d hits, %0d evictions) under %0d settings",
                 refs_checked, hits_seen, evictions_seen, settings_used);
        $display("of policy and frame count, with random idling and one long output stall.");
        if (errors == 0 && pending_outcomes.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
